@@ rtl/lotoa_pkg.sv @@
`timescale 1ns / 1ps
package lotoa_pkg;

  typedef struct packed {
    logic [7:0]  payload_len;
    logic [3:0]  spreading_factor;
    logic [2:0]  coding_rate;
    logic [18:0] bandwidth_hz;
    logic [15:0] preamble_len;
    logic        crc_on;
    logic        implicit_header;
    logic        low_rate_opt;
  } frame_t;

  typedef struct packed {
    logic [11:0] payload_symbols;
    logic [18:0] total_quarter_symbols;
    logic [39:0] airtime_us;
  } toa_t;

  // handoff from the symbol count section to the airtime section
  typedef struct packed {
    logic [11:0] payload_symbols;
    logic [18:0] total_quarter_symbols;
    logic [3:0]  spreading_factor;
    logic [18:0] bandwidth_hz;
  } frame_len_t;

  // block count divider: 10-bit dividend, 5 quotient bits per stage
  localparam int SYM_DIV_W      = 10;
  localparam int SYM_DIV_STEPS  = 5;
  localparam int SYM_DIV_STAGES = SYM_DIV_W / SYM_DIV_STEPS;

  // airtime divider: 52-bit dividend, 2 quotient bits per stage
  localparam int AIR_PROD_W     = 37;
  localparam int AIR_NUM_W      = 52;
  localparam int AIR_DIV_STEPS  = 2;
  localparam int AIR_DIV_STAGES = AIR_NUM_W / AIR_DIV_STEPS;

  // 1e6 us / 4 quarters per symbol
  localparam logic [17:0] US_QUARTER_SCALE       = 18'd250000;
  localparam logic [18:0] PREAMBLE_TAIL_QUARTERS = 19'd17;
  localparam logic [11:0] PSYM_MAX               = 12'hFFF;
  localparam logic [39:0] AIRTIME_MAX            = 40'hFF_FFFF_FFFF;

endpackage

@@ rtl/lotoa_sym.sv @@
`timescale 1ns / 1ps
module lotoa_sym import lotoa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       frame_valid,
  output logic       frame_ready,
  input  frame_t     frame,
  output logic       len_valid,
  input  logic       len_ready,
  output frame_len_t len
);

  localparam int NSTG = SYM_DIV_STAGES + 2;

  typedef struct packed {
    logic [SYM_DIV_W-1:0] nq;
    logic [3:0]           rem;
    logic [3:0]           term;
    logic [2:0]           coding_rate;
    logic [15:0]          preamble_len;
    logic [3:0]           spreading_factor;
    logic [18:0]          bandwidth_hz;
  } sdiv_t;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   rdy;
  sdiv_t           div_q [SYM_DIV_STAGES+1];

  // bubble-collapsing stall chain
  always_comb begin
    rdy[NSTG] = len_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign vld_in      = {vld[NSTG-2:0], frame_valid};
  assign frame_ready = rdy[0];
  assign len_valid   = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // front: ceil(num/(4*term)) == ceil(ceil(num/4)/term), so divide by term only
  logic [11:0] num_pos;
  logic [6:0]  num_neg;
  logic [11:0] num_diff;
  logic [11:0] num_rnd;
  logic [3:0]  term;
  logic [9:0]  dividend;

  always_comb begin
    num_pos  = {1'b0, frame.payload_len, 3'b0} + 12'd28 + {7'b0, frame.crc_on, 4'b0};
    num_neg  = {1'b0, frame.spreading_factor, 2'b0} + (frame.implicit_header ? 7'd20 : 7'd0);
    num_diff = num_pos - {5'b0, num_neg};
    num_rnd  = num_diff + 12'd3;
    if ({1'b0, frame.spreading_factor} <= {3'b0, frame.low_rate_opt, 1'b0}) begin
      term = 4'd1;
    end else begin
      term = frame.spreading_factor - {2'b0, frame.low_rate_opt, 1'b0};
    end
    // non-positive numerator gives zero blocks
    if (num_pos > {5'b0, num_neg}) begin
      dividend = num_rnd[11:2] + {6'b0, term} - 10'd1;
    end else begin
      dividend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      div_q[0].nq               <= dividend;
      div_q[0].rem              <= '0;
      div_q[0].term             <= term;
      div_q[0].coding_rate      <= frame.coding_rate;
      div_q[0].preamble_len     <= frame.preamble_len;
      div_q[0].spreading_factor <= frame.spreading_factor;
      div_q[0].bandwidth_hz     <= frame.bandwidth_hz;
    end
  end

  // restoring division, quotient bits shift in where dividend bits leave
  for (genvar k = 0; k < SYM_DIV_STAGES; k++) begin : g_div
    sdiv_t nxt;

    always_comb begin
      logic [4:0] trial;
      logic [4:0] diff;
      logic       ge;
      nxt = div_q[k];
      for (int s = 0; s < SYM_DIV_STEPS; s++) begin
        trial   = {nxt.rem, nxt.nq[SYM_DIV_W-1]};
        diff    = trial - {1'b0, nxt.term};
        ge      = trial >= {1'b0, nxt.term};
        nxt.rem = ge ? diff[3:0] : trial[3:0];
        nxt.nq  = {nxt.nq[SYM_DIV_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k+1]) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  // finish: symbols and quarter count
  logic [13:0] blk_prod;
  logic [12:0] psym;
  logic [19:0] quarters;

  always_comb begin
    blk_prod = {4'b0, div_q[SYM_DIV_STAGES].nq}
             * {10'b0, {1'b0, div_q[SYM_DIV_STAGES].coding_rate} + 4'd4};
    psym     = 13'd8 + blk_prod[12:0];
    quarters = {2'b0, div_q[SYM_DIV_STAGES].preamble_len, 2'b0}
             + {1'b0, PREAMBLE_TAIL_QUARTERS} + {5'b0, psym, 2'b0};
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      len.payload_symbols       <= (psym > {1'b0, PSYM_MAX}) ? PSYM_MAX : psym[11:0];
      len.total_quarter_symbols <= quarters[18:0];
      len.spreading_factor      <= div_q[SYM_DIV_STAGES].spreading_factor;
      len.bandwidth_hz          <= div_q[SYM_DIV_STAGES].bandwidth_hz;
    end
  end

endmodule

@@ rtl/lotoa_air.sv @@
`timescale 1ns / 1ps
module lotoa_air import lotoa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       len_valid,
  output logic       len_ready,
  input  frame_len_t len,
  output logic       toa_valid,
  input  logic       toa_ready,
  output toa_t       toa
);

  localparam int NSTG = AIR_DIV_STAGES + 3;

  typedef struct packed {
    logic [AIR_PROD_W-1:0] prod;
    logic [3:0]            spreading_factor;
    logic [18:0]           bandwidth_hz;
    logic [11:0]           payload_symbols;
    logic [18:0]           total_quarter_symbols;
  } amul_t;

  typedef struct packed {
    logic [AIR_NUM_W-1:0] nq;
    logic [18:0]          rem;
    logic [18:0]          bandwidth_hz;
    logic                 bw_zero;
    logic [11:0]          payload_symbols;
    logic [18:0]          total_quarter_symbols;
  } adiv_t;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   rdy;
  amul_t           mul_q;
  adiv_t           div_q [AIR_DIV_STAGES+1];

  always_comb begin
    rdy[NSTG] = toa_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign vld_in    = {vld[NSTG-2:0], len_valid};
  assign len_ready = rdy[0];
  assign toa_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // quarters * 250000
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mul_q.prod <= {18'b0, len.total_quarter_symbols} * {19'b0, US_QUARTER_SCALE};
      mul_q.spreading_factor      <= len.spreading_factor;
      mul_q.bandwidth_hz          <= len.bandwidth_hz;
      mul_q.payload_symbols       <= len.payload_symbols;
      mul_q.total_quarter_symbols <= len.total_quarter_symbols;
    end
  end

  // scale by 2^sf, then divide by bandwidth
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      div_q[0].nq <= {{(AIR_NUM_W-AIR_PROD_W){1'b0}}, mul_q.prod} << mul_q.spreading_factor;
      div_q[0].rem                   <= '0;
      div_q[0].bandwidth_hz          <= mul_q.bandwidth_hz;
      div_q[0].bw_zero               <= mul_q.bandwidth_hz == '0;
      div_q[0].payload_symbols       <= mul_q.payload_symbols;
      div_q[0].total_quarter_symbols <= mul_q.total_quarter_symbols;
    end
  end

  for (genvar k = 0; k < AIR_DIV_STAGES; k++) begin : g_div
    adiv_t nxt;

    always_comb begin
      logic [19:0] trial;
      logic [19:0] diff;
      logic        ge;
      nxt = div_q[k];
      for (int s = 0; s < AIR_DIV_STEPS; s++) begin
        trial   = {nxt.rem, nxt.nq[AIR_NUM_W-1]};
        diff    = trial - {1'b0, nxt.bandwidth_hz};
        ge      = trial >= {1'b0, nxt.bandwidth_hz};
        nxt.rem = ge ? diff[18:0] : trial[18:0];
        nxt.nq  = {nxt.nq[AIR_NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k+2]) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  logic air_ovf;
  assign air_ovf = div_q[AIR_DIV_STAGES].bw_zero || (|div_q[AIR_DIV_STAGES].nq[AIR_NUM_W-1:40]);

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      toa.payload_symbols       <= div_q[AIR_DIV_STAGES].payload_symbols;
      toa.total_quarter_symbols <= div_q[AIR_DIV_STAGES].total_quarter_symbols;
      toa.airtime_us            <= air_ovf ? AIRTIME_MAX : div_q[AIR_DIV_STAGES].nq[39:0];
    end
  end

endmodule

@@ rtl/lora_time_on_air_unit.sv @@
// LoRa time-on-air unit. Each frame transaction (payload length, SF, coding rate,
// bandwidth, preamble, CRC/implicit-header/low-data-rate flags) yields one result
// with the payload symbol count, the frame length in quarter symbols and the air
// time in whole microseconds. A new frame can be taken every cycle unless the
// pipeline is full and stalled. 4 stages compute the symbol count (including a
// 10-bit block divider, 5 bits per stage) and 29 the air time, dominated by the
// 52-bit by 19-bit long division at 2 quotient bits per stage. Result-side stalls
// fill bubbles first, so frames keep being taken until the pipeline is full.
`timescale 1ns / 1ps
module lora_time_on_air_unit import lotoa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   frame_valid,
  output logic   frame_ready,
  input  frame_t frame,
  output logic   toa_valid,
  input  logic   toa_ready,
  output toa_t   toa
);

  logic       len_valid;
  logic       len_ready;
  frame_len_t len;

  lotoa_sym u_sym (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .len_valid   (len_valid),
    .len_ready   (len_ready),
    .len         (len)
  );

  lotoa_air u_air (
    .clk       (clk),
    .rst       (rst),
    .len_valid (len_valid),
    .len_ready (len_ready),
    .len       (len),
    .toa_valid (toa_valid),
    .toa_ready (toa_ready),
    .toa       (toa)
  );

  // 17 tail quarters plus whole symbols: always 1 mod 4
  a_quarter_align: assert property (@(posedge clk) disable iff (rst)
    toa_valid |-> toa.total_quarter_symbols[1:0] == 2'b01)
    else $error("quarter count misaligned");

  a_min_symbols: assert property (@(posedge clk) disable iff (rst)
    toa_valid |-> toa.payload_symbols >= 12'd8)
    else $error("payload symbols below eight");

  a_total_covers_payload: assert property (@(posedge clk) disable iff (rst)
    toa_valid |-> ({5'b0, toa.payload_symbols, 2'b0} + {1'b0, PREAMBLE_TAIL_QUARTERS})
                  <= {1'b0, toa.total_quarter_symbols})
    else $error("total shorter than payload");

  // input side only backs up once the whole pipeline is full and blocked
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !frame_ready |-> toa_valid && !toa_ready)
    else $error("input stalled with room in pipeline");

endmodule
